[design/wls_pkg.sv]
package wls_pkg;

    localparam int unsigned TIME_W = 63;
    localparam int unsigned CFG_W  = 32;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [CFG_W-1:0] BASE_BACKOFF_US = 32'd1000000;
    localparam logic [CFG_W-1:0] CAP_BACKOFF_US  = 32'd8000000;

    // attempt count stops here (range 1..7)
    localparam logic [2:0] MAX_ATTEMPTS = 3'd5;

    localparam logic [CFG_W-1:0] RST_CONNECT_TIMEOUT = 32'd15000000;
    localparam logic [CFG_W-1:0] RST_CONFIRM_TIMEOUT = 32'd30000000;
    localparam logic [CFG_W-1:0] RST_HANDOVER_DELAY  = 32'd2000000;

    localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HANDOVER_DELAY  = 2'd2;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_START   = 3'd1,
        OP_TEST    = 3'd2,
        OP_ONLINE  = 3'd3,
        OP_LOST    = 3'd4,
        OP_CONFIRM = 3'd5,
        OP_RECOVER = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        PH_AP         = 3'd0,
        PH_CONNECTING = 3'd1,
        PH_STATION    = 3'd2,
        PH_RECOVERY   = 3'd3,
        PH_TESTING    = 3'd4,
        PH_CONFIRMING = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        EF_WAIT     = 2'd0,
        EF_CLOSE_AP = 2'd1,
        EF_OPEN_AP  = 2'd2,
        EF_TRY      = 2'd3
    } t_effect;

    typedef struct packed {
        t_op               operation;
        logic [TIME_W-1:0] now;
        logic              station_mode;
        logic              held;
    } t_event;

    typedef struct packed {
        t_effect effect;
        logic    confirm_ok;
        t_phase  phase;
        logic    online;
        logic    ap_open;
    } t_result;

    typedef struct packed {
        logic [CFG_W-1:0] connect_timeout_us;
        logic [CFG_W-1:0] confirm_timeout_us;
        logic [CFG_W-1:0] handover_delay_us;
    } t_cfg;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] t,
                                                  input logic [CFG_W-1:0] d);
        logic [TIME_W:0] s;
        s = {1'b0, t} + {{(TIME_W+1-CFG_W){1'b0}}, d};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    // doubling backoff from the attempt count, capped
    function automatic logic [CFG_W-1:0] backoff_us(input logic [2:0] cnt);
        logic [CFG_W-1:0] d;
        unique case (cnt)
            3'd0, 3'd1: d = BASE_BACKOFF_US;
            3'd2:       d = BASE_BACKOFF_US << 1;
            3'd3:       d = BASE_BACKOFF_US << 2;
            default:    d = CAP_BACKOFF_US;
        endcase
        return d;
    endfunction

endpackage

[design/wls_in_if.sv]
interface wls_in_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  operation;
    logic [wls_pkg::TIME_W-1:0]  now;
    logic                        station_mode;
    logic                        held;

    modport source (output valid, output operation, output now, output station_mode,
                    output held, input ready);
    modport sink   (input valid, input operation, input now, input station_mode,
                    input held, output ready);
endinterface

[design/wls_out_if.sv]
interface wls_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] effect;
    logic       confirm_ok;
    logic [2:0] phase;
    logic       online;
    logic       ap_open;

    modport source (output valid, output effect, output confirm_ok, output phase,
                    output online, output ap_open, input ready);
    modport sink   (input valid, input effect, input confirm_ok, input phase,
                    input online, input ap_open, output ready);
endinterface

[design/wls_cfg.sv]
module wls_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wls_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [wls_pkg::CFG_W-1:0]     i_cfg_data,
    output wls_pkg::t_cfg                 o_cfg
);

    wls_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.connect_timeout_us <= wls_pkg::RST_CONNECT_TIMEOUT;
            r_cfg.confirm_timeout_us <= wls_pkg::RST_CONFIRM_TIMEOUT;
            r_cfg.handover_delay_us  <= wls_pkg::RST_HANDOVER_DELAY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wls_pkg::CFG_CONNECT_TIMEOUT: r_cfg.connect_timeout_us <= i_cfg_data;
                wls_pkg::CFG_CONFIRM_TIMEOUT: r_cfg.confirm_timeout_us <= i_cfg_data;
                wls_pkg::CFG_HANDOVER_DELAY:  r_cfg.handover_delay_us  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[design/wls_core.sv]
module wls_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  wls_pkg::t_event  i_evt,
    input  wls_pkg::t_cfg    i_cfg,
    output wls_pkg::t_result o_res
);

    wls_pkg::t_phase              r_phase, n_phase;
    logic                         r_online, n_online;
    logic                         r_ap, n_ap;
    logic [wls_pkg::TIME_W-1:0]   r_deadline, n_deadline;
    logic [wls_pkg::TIME_W-1:0]   r_retry, n_retry;
    logic [wls_pkg::TIME_W-1:0]   r_handover, n_handover;
    logic [2:0]                   r_attempt, n_attempt;

    wls_pkg::t_effect             effect;
    logic                         confirm_ok;

    logic [wls_pkg::TIME_W-1:0]   sum_conn, sum_confirm, sum_handover, sum_base, sum_backoff;
    logic [2:0]                   attempt_inc;
    logic                         handover_due, release_ap;

    assign attempt_inc  = (r_attempt < wls_pkg::MAX_ATTEMPTS) ? r_attempt + 3'd1 : r_attempt;
    assign sum_conn     = wls_pkg::sat_add(i_evt.now, i_cfg.connect_timeout_us);
    assign sum_confirm  = wls_pkg::sat_add(i_evt.now, i_cfg.confirm_timeout_us);
    assign sum_handover = wls_pkg::sat_add(i_evt.now, i_cfg.handover_delay_us);
    assign sum_base     = wls_pkg::sat_add(i_evt.now, wls_pkg::BASE_BACKOFF_US);
    assign sum_backoff  = wls_pkg::sat_add(i_evt.now, wls_pkg::backoff_us(attempt_inc));

    assign handover_due = (r_handover != '0) && (i_evt.now >= r_handover);
    assign release_ap   = !i_evt.held && (r_phase == wls_pkg::PH_STATION ||
                          (r_phase == wls_pkg::PH_CONFIRMING && i_evt.now >= r_deadline));

    always_comb begin
        n_phase    = r_phase;
        n_online   = r_online;
        n_ap       = r_ap;
        n_deadline = r_deadline;
        n_retry    = r_retry;
        n_handover = r_handover;
        n_attempt  = r_attempt;
        effect     = wls_pkg::EF_WAIT;
        confirm_ok = 1'b0;

        unique case (i_evt.operation)
            wls_pkg::OP_TICK: begin
                if (r_online) begin
                    if (r_ap && (handover_due || release_ap)) begin
                        n_ap    = 1'b0;
                        n_phase = wls_pkg::PH_STATION;
                        effect  = wls_pkg::EF_CLOSE_AP;
                    end
                end else if ((r_phase == wls_pkg::PH_CONNECTING ||
                              r_phase == wls_pkg::PH_TESTING) &&
                             i_evt.now >= r_deadline) begin
                    // connect or test timed out: fall back to the AP
                    n_phase    = wls_pkg::PH_RECOVERY;
                    n_ap       = 1'b1;
                    n_deadline = '0;
                    n_retry    = sum_conn;
                    n_handover = '0;
                    n_attempt  = '0;
                    effect     = wls_pkg::EF_OPEN_AP;
                end else if (!(r_phase == wls_pkg::PH_AP ||
                               (r_phase == wls_pkg::PH_RECOVERY && i_evt.held) ||
                               i_evt.now < r_retry)) begin
                    n_attempt = attempt_inc;
                    n_retry   = (r_phase == wls_pkg::PH_RECOVERY) ? sum_conn : sum_backoff;
                    effect    = wls_pkg::EF_TRY;
                end
            end
            wls_pkg::OP_START: begin
                n_phase    = i_evt.station_mode ? wls_pkg::PH_CONNECTING : wls_pkg::PH_AP;
                n_online   = 1'b0;
                n_ap       = !i_evt.station_mode;
                n_deadline = sum_conn;
                n_retry    = i_evt.now;
                n_handover = '0;
                n_attempt  = '0;
            end
            wls_pkg::OP_TEST: begin
                n_phase    = wls_pkg::PH_TESTING;
                n_online   = 1'b0;
                n_ap       = 1'b1;
                n_deadline = sum_conn;
                n_retry    = i_evt.now;
                n_handover = '0;
                n_attempt  = '0;
            end
            wls_pkg::OP_ONLINE: begin
                n_online   = 1'b1;
                n_phase    = (r_phase == wls_pkg::PH_TESTING) ? wls_pkg::PH_CONFIRMING
                                                              : wls_pkg::PH_STATION;
                n_deadline = sum_confirm;
                n_handover = '0;
            end
            wls_pkg::OP_LOST: begin
                n_online   = 1'b0;
                n_handover = '0;
                if (r_phase == wls_pkg::PH_STATION || r_phase == wls_pkg::PH_CONFIRMING) begin
                    n_phase    = r_ap ? wls_pkg::PH_RECOVERY : wls_pkg::PH_CONNECTING;
                    n_deadline = sum_conn;
                    n_retry    = sum_base;
                    n_attempt  = '0;
                end
            end
            wls_pkg::OP_CONFIRM: begin
                if (r_online && r_ap && (r_phase == wls_pkg::PH_CONFIRMING ||
                                         r_phase == wls_pkg::PH_STATION)) begin
                    // zero means unscheduled, so a later confirm keeps the first time
                    if (r_handover == '0) begin
                        n_handover = sum_handover;
                    end
                    confirm_ok = 1'b1;
                end
            end
            wls_pkg::OP_RECOVER: begin
                n_phase    = wls_pkg::PH_RECOVERY;
                n_online   = 1'b0;
                n_ap       = 1'b1;
                n_deadline = '0;
                n_retry    = sum_conn;
                n_handover = '0;
                n_attempt  = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= wls_pkg::PH_AP;
            r_online   <= 1'b0;
            r_ap       <= 1'b0;
            r_deadline <= '0;
            r_retry    <= '0;
            r_handover <= '0;
            r_attempt  <= '0;
        end else if (i_fire) begin
            r_phase    <= n_phase;
            r_online   <= n_online;
            r_ap       <= n_ap;
            r_deadline <= n_deadline;
            r_retry    <= n_retry;
            r_handover <= n_handover;
            r_attempt  <= n_attempt;
        end
    end

    assign o_res.effect     = effect;
    assign o_res.confirm_ok = confirm_ok;
    assign o_res.phase      = n_phase;
    assign o_res.online     = n_online;
    assign o_res.ap_open    = n_ap;

endmodule

[design/wifi_link_supervisor.sv]
// Station link supervisor with fallback access point.
// i_evt (valid/ready) carries one timestamped event word: tick, start, test,
// online, lost, confirm or recover, with now, station_mode and held.
// o_res (valid/ready) returns one word per event: effect, confirm_ok and the
// phase, online and ap_open flags as they stand after the event.
// Timeouts are set through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them
// only while no event is in flight (not enforced here); unknown indexes are dropped.
// An accepted event is registered in the input register, processed by the core, and its
// result word is registered in the output register (two register stages).
// Throughput: one event per cycle while o_res is ready; the state update of one
// event feeds the next event directly from the link state registers.
// When the receiver stalls, the output register holds its word, the input
// register fills, and i_evt.ready drops until o_res moves again.
// Synchronous reset returns the link to the AP phase with AP closed, all
// deadlines zero, and timeouts to their defaults; both stages are emptied.
module wifi_link_supervisor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    wls_in_if.sink                        i_evt,
    wls_out_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [wls_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [wls_pkg::CFG_W-1:0]     i_cfg_data
);

    logic              r_in_valid, r_out_valid;
    wls_pkg::t_event   r_in;
    wls_pkg::t_result  r_out;
    wls_pkg::t_result  core_res;
    wls_pkg::t_cfg     cfg;
    logic              advance, in_accept;

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_evt.ready = !r_in_valid || advance;
    assign in_accept   = i_evt.valid && i_evt.ready;

    wls_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    wls_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_evt   (r_in),
        .i_cfg   (cfg),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.operation    <= wls_pkg::t_op'(i_evt.operation);
            r_in.now          <= i_evt.now;
            r_in.station_mode <= i_evt.station_mode;
            r_in.held         <= i_evt.held;
        end
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.effect     = r_out.effect;
    assign o_res.confirm_ok = r_out.confirm_ok;
    assign o_res.phase      = r_out.phase;
    assign o_res.online     = r_out.online;
    assign o_res.ap_open    = r_out.ap_open;

endmodule

[design/wls_checker.sv]
module wls_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_effect,
    input logic       i_confirm_ok,
    input logic [2:0] i_phase,
    input logic       i_online,
    input logic       i_ap_open
);

    // output register is emptied by reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result word valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_effect) &&
            $stable(i_phase) && $stable(i_confirm_ok))
        else $error("stalled result word changed");

    // link is up exactly in the station and confirming phases
    a_online_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_online == (i_phase == wls_pkg::PH_STATION ||
                                      i_phase == wls_pkg::PH_CONFIRMING)))
        else $error("online flag disagrees with phase");

    a_confirm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_confirm_ok |-> i_online && i_ap_open && i_effect == wls_pkg::EF_WAIT)
        else $error("confirm accepted without link and AP");

    a_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_effect != wls_pkg::EF_CLOSE_AP || (!i_ap_open && i_online &&
                                                  i_phase == wls_pkg::PH_STATION)) &&
            (i_effect != wls_pkg::EF_OPEN_AP || (i_ap_open && !i_online &&
                                                 i_phase == wls_pkg::PH_RECOVERY)) &&
            (i_effect != wls_pkg::EF_TRY || !i_online))
        else $error("effect inconsistent with resulting state");

endmodule

bind wifi_link_supervisor wls_checker u_wls_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_effect     (o_res.effect),
    .i_confirm_ok (o_res.confirm_ok),
    .i_phase      (o_res.phase),
    .i_online     (o_res.online),
    .i_ap_open    (o_res.ap_open)
);

[sim/wifi_link_supervisor_tb.sv]
`timescale 1ns / 100ps

module wifi_link_supervisor_tb;

    localparam logic [2:0]                    OP_UNUSED      = 3'd7;
    localparam logic [wls_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam int                            DRAIN_LIMIT    = 5000;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_COIN,
        RX_PERIODIC,
        RX_SPARSE
    } t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                          i_cfg_we;
    logic [wls_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [wls_pkg::CFG_W-1:0]     i_cfg_data;

    wls_in_if  evt ();
    wls_out_if res ();

    wifi_link_supervisor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (evt),
        .o_res      (res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // predicted link state and timeouts
    wls_pkg::t_phase            lk_phase;
    logic                       lk_online;
    logic                       lk_ap;
    logic [wls_pkg::TIME_W-1:0] lk_deadline;
    logic [wls_pkg::TIME_W-1:0] lk_retry;
    logic [wls_pkg::TIME_W-1:0] lk_handover;
    logic [2:0]                 lk_attempts;
    logic [wls_pkg::CFG_W-1:0]  cfg_connect;
    logic [wls_pkg::CFG_W-1:0]  cfg_confirm;
    logic [wls_pkg::CFG_W-1:0]  cfg_handover;

    wls_pkg::t_result expected_results[$];
    wls_pkg::t_result want_word;

    logic [wls_pkg::TIME_W-1:0] now_us;
    int burst_left;
    bit sender_gaps;
    int hold_request;
    int hold_left;
    int rx_mode_left;
    int rx_cycle;
    t_rx_mode rx_mode;

    int mismatch_count;
    int words_checked;
    int events_sent;
    int cfg_writes;
    int input_stall_cycles;
    int confirms_accepted;
    int effect_tally[4];

    function automatic logic [wls_pkg::TIME_W-1:0] time_plus(
        input logic [wls_pkg::TIME_W-1:0] t, input logic [wls_pkg::CFG_W-1:0] d);
        logic [wls_pkg::TIME_W:0] sum;
        sum = {1'b0, t} + d;
        return sum[wls_pkg::TIME_W] ? wls_pkg::TIME_MAX : sum[wls_pkg::TIME_W-1:0];
    endfunction

    function automatic void clear_state(input wls_pkg::t_phase ph, input logic ap);
        lk_phase    = ph;
        lk_online   = 1'b0;
        lk_ap       = ap;
        lk_deadline = '0;
        lk_retry    = '0;
        lk_handover = '0;
        lk_attempts = '0;
    endfunction

    function automatic void go_recovery(input logic [wls_pkg::TIME_W-1:0] t);
        clear_state(wls_pkg::PH_RECOVERY, 1'b1);
        lk_retry = time_plus(t, cfg_connect);
    endfunction

    // next link state and the result word for one event
    function automatic wls_pkg::t_result advance_link(input logic [2:0] op,
                                                      input logic [wls_pkg::TIME_W-1:0] t,
                                                      input logic sm, input logic hd);
        wls_pkg::t_result r;
        logic [wls_pkg::CFG_W-1:0] dly;
        logic [2:0] sh;
        logic due;
        logic rel;
        r = '0;
        r.effect = wls_pkg::EF_WAIT;
        case (op)
            wls_pkg::OP_TICK: begin
                if (lk_online) begin
                    due = (lk_handover != 0) && (t >= lk_handover);
                    rel = !hd && (lk_phase == wls_pkg::PH_STATION ||
                                  (lk_phase == wls_pkg::PH_CONFIRMING && t >= lk_deadline));
                    if (lk_ap && (due || rel)) begin
                        lk_ap    = 1'b0;
                        lk_phase = wls_pkg::PH_STATION;
                        r.effect = wls_pkg::EF_CLOSE_AP;
                    end
                end else if ((lk_phase == wls_pkg::PH_CONNECTING ||
                              lk_phase == wls_pkg::PH_TESTING) && t >= lk_deadline) begin
                    go_recovery(t);
                    r.effect = wls_pkg::EF_OPEN_AP;
                end else if (!(lk_phase == wls_pkg::PH_AP ||
                               (lk_phase == wls_pkg::PH_RECOVERY && hd) ||
                               t < lk_retry)) begin
                    if (lk_attempts < wls_pkg::MAX_ATTEMPTS) lk_attempts = lk_attempts + 3'd1;
                    if (lk_phase == wls_pkg::PH_RECOVERY) begin
                        dly = cfg_connect;
                    end else begin
                        sh  = (lk_attempts == 0) ? 3'd0 : lk_attempts - 3'd1;
                        dly = wls_pkg::BASE_BACKOFF_US << sh;
                        if (dly > wls_pkg::CAP_BACKOFF_US) dly = wls_pkg::CAP_BACKOFF_US;
                    end
                    lk_retry = time_plus(t, dly);
                    r.effect = wls_pkg::EF_TRY;
                end
            end
            wls_pkg::OP_START: begin
                clear_state(sm ? wls_pkg::PH_CONNECTING : wls_pkg::PH_AP, !sm);
                lk_deadline = time_plus(t, cfg_connect);
                lk_retry    = t;
            end
            wls_pkg::OP_TEST: begin
                clear_state(wls_pkg::PH_TESTING, 1'b1);
                lk_deadline = time_plus(t, cfg_connect);
                lk_retry    = t;
            end
            wls_pkg::OP_ONLINE: begin
                lk_online   = 1'b1;
                lk_phase    = (lk_phase == wls_pkg::PH_TESTING) ? wls_pkg::PH_CONFIRMING
                                                                : wls_pkg::PH_STATION;
                lk_deadline = time_plus(t, cfg_confirm);
                lk_handover = '0;
            end
            wls_pkg::OP_LOST: begin
                lk_online   = 1'b0;
                lk_handover = '0;
                if (lk_phase == wls_pkg::PH_STATION || lk_phase == wls_pkg::PH_CONFIRMING) begin
                    lk_phase    = lk_ap ? wls_pkg::PH_RECOVERY : wls_pkg::PH_CONNECTING;
                    lk_deadline = time_plus(t, cfg_connect);
                    lk_retry    = time_plus(t, wls_pkg::BASE_BACKOFF_US);
                    lk_attempts = '0;
                end
            end
            wls_pkg::OP_CONFIRM: begin
                if (lk_online && lk_ap && (lk_phase == wls_pkg::PH_CONFIRMING ||
                                           lk_phase == wls_pkg::PH_STATION)) begin
                    // zero handover time means not scheduled, so it may stay zero
                    if (lk_handover == 0) lk_handover = time_plus(t, cfg_handover);
                    r.confirm_ok = 1'b1;
                end
            end
            wls_pkg::OP_RECOVER: go_recovery(t);
            default: ;
        endcase
        r.phase   = lk_phase;
        r.online  = lk_online;
        r.ap_open = lk_ap;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch at word %0d, %s: got 0x%0h, want 0x%0h",
                 $time, words_checked, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_event(input logic [2:0] op, input logic [wls_pkg::TIME_W-1:0] t,
                              input logic sm, input logic hd);
        wls_pkg::t_result w;
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (sender_gaps && $urandom_range(0, 2) != 0) gap = $urandom_range(1, 5);
        end
        burst_left--;
        if (gap > 0) begin
            @(negedge i_clk);
            evt.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        evt.valid        <= 1'b1;
        evt.operation    <= op;
        evt.now          <= t;
        evt.station_mode <= sm;
        evt.held         <= hd;
        do @(posedge i_clk); while (!evt.ready);
        w = advance_link(op, t, sm, hd);
        expected_results.push_back(w);
        effect_tally[w.effect]++;
        confirms_accepted += w.confirm_ok;
        events_sent++;
    endtask

    task automatic write_cfg(input logic [wls_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wls_pkg::CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            wls_pkg::CFG_CONNECT_TIMEOUT: cfg_connect  = data;
            wls_pkg::CFG_CONFIRM_TIMEOUT: cfg_confirm  = data;
            wls_pkg::CFG_HANDOVER_DELAY:  cfg_handover = data;
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // stop sending, then wait for every pending result word
    task automatic wait_idle();
        int waited;
        @(negedge i_clk);
        evt.valid <= 1'b0;
        burst_left = 0;
        for (waited = 0; waited < DRAIN_LIMIT && expected_results.size() != 0; waited++)
            @(posedge i_clk);
        if (expected_results.size() != 0) begin
            report_mismatch("result words never returned", expected_results.size(), 0);
            expected_results.delete();
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_timeouts(input logic [wls_pkg::CFG_W-1:0] conn,
                                  input logic [wls_pkg::CFG_W-1:0] conf,
                                  input logic [wls_pkg::CFG_W-1:0] hand);
        wait_idle();
        write_cfg(wls_pkg::CFG_CONNECT_TIMEOUT, conn);
        write_cfg(wls_pkg::CFG_CONFIRM_TIMEOUT, conf);
        write_cfg(wls_pkg::CFG_HANDOVER_DELAY, hand);
    endtask

    // mostly forward steps on the scale of the timeouts, some stalls, rewinds and jumps
    function automatic logic [wls_pkg::TIME_W-1:0] next_now(
        input logic [wls_pkg::TIME_W-1:0] cur, input logic [63:0] scale);
        logic [63:0] rnd;
        logic [63:0] sum;
        int unsigned r;
        r   = $urandom_range(0, 99);
        rnd = {$urandom, $urandom};
        if (r < 5) return cur;
        if (r < 8) return ({1'b0, cur} > scale) ? cur - scale[wls_pkg::TIME_W-1:0] : '0;
        if (r < 10) return rnd[wls_pkg::TIME_W-1:0];
        sum = {1'b0, cur} + rnd % ((r < 70 ? scale / 2 : scale * 2) + 1);
        if (sum > {1'b0, wls_pkg::TIME_MAX}) return wls_pkg::TIME_MAX - $urandom;
        return sum[wls_pkg::TIME_W-1:0];
    endfunction

    function automatic logic [2:0] pick_operation(input int tick_pct);
        int unsigned r;
        if ($urandom_range(0, 99) < tick_pct) return wls_pkg::OP_TICK;
        r = $urandom_range(0, 99);
        if (r < 14) return wls_pkg::OP_START;
        if (r < 26) return wls_pkg::OP_TEST;
        if (r < 46) return wls_pkg::OP_ONLINE;
        if (r < 62) return wls_pkg::OP_LOST;
        if (r < 80) return wls_pkg::OP_CONFIRM;
        if (r < 96) return wls_pkg::OP_RECOVER;
        return OP_UNUSED;
    endfunction

    task automatic test_random_mix(input int n, input int tick_pct, input logic [63:0] scale);
        for (int i = 0; i < n; i++) begin
            now_us = next_now(now_us, scale);
            send_event(pick_operation(tick_pct), now_us, $urandom_range(0, 9) < 7,
                       $urandom_range(0, 9) < 3);
        end
    endtask

    // walks connect backoff, timeout into recovery, confirm and handover, saturation
    task automatic test_directed_walk();
        send_event(wls_pkg::OP_CONFIRM, 63'd0, 1'b0, 1'b0);
        send_event(wls_pkg::OP_TICK, 63'd0, 1'b0, 1'b0);
        send_event(OP_UNUSED, 63'd0, 1'b1, 1'b1);
        send_event(wls_pkg::OP_START, 63'd0, 1'b1, 1'b0);
        send_event(wls_pkg::OP_TICK, 63'd0, 1'b0, 1'b0);
        send_event(wls_pkg::OP_TICK, 63'd1000000, 1'b0, 1'b1);
        send_event(wls_pkg::OP_TICK, 63'd3000000, 1'b0, 1'b0);
        send_event(wls_pkg::OP_TICK, 63'd7000000, 1'b0, 1'b0);
        send_event(wls_pkg::OP_TICK, 63'd15000000, 1'b0, 1'b0);
        send_event(wls_pkg::OP_TICK, 63'd30000000, 1'b0, 1'b1);
        send_event(wls_pkg::OP_TICK, 63'd30000000, 1'b0, 1'b0);
        send_event(wls_pkg::OP_ONLINE, 63'd31000000, 1'b0, 1'b0);
        send_event(wls_pkg::OP_CONFIRM, 63'd31000000, 1'b0, 1'b0);
        send_event(wls_pkg::OP_TICK, 63'd32000000, 1'b0, 1'b1);
        send_event(wls_pkg::OP_TICK, 63'd33000000, 1'b0, 1'b1);
        send_event(wls_pkg::OP_LOST, 63'd34000000, 1'b0, 1'b0);
        send_event(wls_pkg::OP_TICK, 63'd20000000, 1'b0, 1'b0);
        send_event(wls_pkg::OP_TEST, 63'd40000000, 1'b0, 1'b0);
        send_event(wls_pkg::OP_ONLINE, 63'd41000000, 1'b0, 1'b0);
        send_event(wls_pkg::OP_TICK, 63'd71000000, 1'b0, 1'b0);
        send_event(wls_pkg::OP_START, 63'd72000000, 1'b0, 1'b1);
        send_event(wls_pkg::OP_RECOVER, wls_pkg::TIME_MAX - 63'd5, 1'b0, 1'b0);
        send_event(wls_pkg::OP_TICK, wls_pkg::TIME_MAX, 1'b0, 1'b0);
    endtask

    // zero handover delay at time zero leaves the handover unscheduled
    task automatic test_handover_at_zero();
        wait_idle();
        write_cfg(wls_pkg::CFG_HANDOVER_DELAY, '0);
        write_cfg(CFG_UNUSED_IDX, 32'hffff_ffff);
        send_event(wls_pkg::OP_TEST, 63'd0, 1'b0, 1'b0);
        send_event(wls_pkg::OP_ONLINE, 63'd0, 1'b0, 1'b0);
        send_event(wls_pkg::OP_CONFIRM, 63'd0, 1'b0, 1'b0);
        send_event(wls_pkg::OP_CONFIRM, 63'd0, 1'b0, 1'b0);
        send_event(wls_pkg::OP_TICK, 63'd0, 1'b0, 1'b1);
        send_event(wls_pkg::OP_TICK, 63'd5, 1'b0, 1'b0);
        send_event(wls_pkg::OP_TICK, 63'd30000000, 1'b0, 1'b0);
    endtask

    task automatic test_timeout_settings();
        apply_timeouts(wls_pkg::RST_CONNECT_TIMEOUT, wls_pkg::RST_CONFIRM_TIMEOUT,
                       wls_pkg::RST_HANDOVER_DELAY);
        now_us = '0;
        test_random_mix(130, 45, 64'd3000000);
        // long connect window, tick heavy: backoff climbs to its cap
        apply_timeouts(32'd40000000, 32'd10000000, 32'd500000);
        test_random_mix(130, 75, 64'd1500000);
        apply_timeouts(32'd1, 32'd1, 32'd1);
        test_random_mix(100, 45, 64'd4);
        // widest timeouts near the top of time: deadline sums saturate
        apply_timeouts('1, '1, '1);
        now_us = wls_pkg::TIME_MAX - (63'd1 << 34);
        test_random_mix(100, 45, 64'd1 << 31);
        repeat (3) begin
            apply_timeouts($urandom_range(1, 20000000), $urandom_range(1, 20000000),
                           $urandom_range(1, 20000000));
            now_us = {$urandom, $urandom} >> 24;
            test_random_mix(80, 50, 64'd2000000);
        end
    endtask

    // receiver holds off while words keep coming, so the input side backs up
    task automatic test_input_stall();
        wait_idle();
        @(posedge i_clk);
        hold_request = 80;
        sender_gaps  = 1'b0;
        test_random_mix(40, 60, 64'd3000000);
        sender_gaps  = 1'b1;
    endtask

    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (rx_mode_left == 0) begin
            rx_mode      = t_rx_mode'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 200);
        end
        rx_mode_left--;
        rx_cycle++;
        if (hold_left != 0) begin
            hold_left--;
            res.ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_STEADY:   res.ready <= 1'b1;
                RX_COIN:     res.ready <= $urandom_range(0, 9) < 7;
                RX_PERIODIC: res.ready <= (rx_cycle % 5) < 3;
                default:     res.ready <= $urandom_range(0, 3) == 0;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (evt.valid && !evt.ready) input_stall_cycles++;
            if (res.valid && res.ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result word with nothing pending",
                                    {res.effect, res.confirm_ok, res.phase, res.online,
                                     res.ap_open}, 0);
                end else begin
                    want_word = expected_results.pop_front();
                    if (res.effect !== want_word.effect)
                        report_mismatch("effect", res.effect, want_word.effect);
                    if (res.confirm_ok !== want_word.confirm_ok)
                        report_mismatch("confirm_ok", res.confirm_ok, want_word.confirm_ok);
                    if (res.phase !== want_word.phase)
                        report_mismatch("phase", res.phase, want_word.phase);
                    if (res.online !== want_word.online)
                        report_mismatch("online", res.online, want_word.online);
                    if (res.ap_open !== want_word.ap_open)
                        report_mismatch("ap_open", res.ap_open, want_word.ap_open);
                end
                words_checked++;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("timed out after %0d result words", words_checked);
        $display("wifi_link_supervisor_tb: FAIL");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        evt.valid        = 1'b0;
        evt.operation    = '0;
        evt.now          = '0;
        evt.station_mode = 1'b0;
        evt.held         = 1'b0;
        res.ready        = 1'b0;
        hold_request     = 0;
        hold_left        = 0;
        rx_mode_left     = 0;
        rx_cycle         = 0;
        burst_left       = 0;
        sender_gaps      = 1'b1;
        now_us           = '0;
        cfg_connect      = wls_pkg::RST_CONNECT_TIMEOUT;
        cfg_confirm      = wls_pkg::RST_CONFIRM_TIMEOUT;
        cfg_handover     = wls_pkg::RST_HANDOVER_DELAY;
        clear_state(wls_pkg::PH_AP, 1'b0);
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_walk();
        test_handover_at_zero();
        test_timeout_settings();
        test_input_stall();

        wait_idle();
        repeat (6) @(posedge i_clk);
        $display("%0d events, %0d result words, %0d register writes, %0d cycles of input stall",
                 events_sent, words_checked, cfg_writes, input_stall_cycles);
        $display("effects wait/close/open/try: %0d/%0d/%0d/%0d, confirms accepted: %0d",
                 effect_tally[0], effect_tally[1], effect_tally[2], effect_tally[3],
                 confirms_accepted);
        if (mismatch_count == 0) begin
            $display("wifi_link_supervisor_tb: PASS");
        end else begin
            $display("wifi_link_supervisor_tb: FAIL");
        end
        $finish;
    end

endmodule
